>>> sv/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EFQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EFQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define EFQ_ASSERT_RST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/efq_pkg.sv
// Package for the event fanout queue block: sizes, field widths, op codes,
// sequencer states and the control structs between sequencer and queue control.
// No dependencies.
`timescale 1ns / 1ps

package efq_pkg;

  // Sizing
  localparam int NUM_EVENT_TYPES     = 16;
  localparam int LISTENERS_PER_EVENT = 4;
  localparam int QUEUE_DEPTH         = 8;
  localparam int NUM_QUEUES          = 8;

  // Item field widths
  localparam int OP_W      = 2;
  localparam int EVENT_W   = 4;
  localparam int QUEUE_W   = 3;
  localparam int DELIV_W   = 3;
  localparam int DELIV_MAX = 7;

  // Derived widths
  localparam int EV_AW  = (NUM_EVENT_TYPES > 1) ? $clog2(NUM_EVENT_TYPES) : 1;
  localparam int QI_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LC_W   = $clog2(LISTENERS_PER_EVENT + 1);
  localparam int LT_DEPTH = NUM_EVENT_TYPES * LISTENERS_PER_EVENT;
  localparam int LT_AW  = (LT_DEPTH > 1) ? $clog2(LT_DEPTH) : 1;
  localparam int QS_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int QS_AW  = (QS_DEPTH > 1) ? $clog2(QS_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_SUBSCRIBE = 2'd0,
    OP_PUBLISH   = 2'd1,
    OP_POP       = 2'd2,
    OP_INIT      = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_LWAIT    = 5'b00100,
    S_POPWAIT  = 5'b01000,
    S_FIN      = 5'b10000
  } state_t;

  // Command to the queue pointer unit
  typedef struct packed {
    logic [QI_W-1:0] sel;
    logic            push;
    logic            pop;
    logic            init;
  } qcmd_t;

  // Status of the selected queue
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
  } qstat_t;

endpackage

>>> sv/efq_if.sv
// Valid/ready channel interfaces for the event fanout queue block.
// Depends on efq_pkg for field widths.
`timescale 1ns / 1ps

interface efq_in_if import efq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [EVENT_W-1:0] event_id;
  logic [QUEUE_W-1:0] queue_id;

  modport source (output valid, op, event_id, queue_id, input ready);
  modport sink   (input valid, op, event_id, queue_id, output ready);
endinterface

interface efq_out_if import efq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_out;
  logic               got_event;
  logic               refused;
  logic [DELIV_W-1:0] delivered;

  modport source (output valid, event_out, got_event, refused, delivered, input ready);
  modport sink   (input valid, event_out, got_event, refused, delivered, output ready);
endinterface

>>> sv/efq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module efq_ram #(
  parameter int DW    = 4,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/efq_qctl.sv
// Queue pointer unit: write/read pointers and full flags of all queues, one
// shared increment-and-compare path applied to the selected queue.
// Depends on efq_pkg.
`timescale 1ns / 1ps

module efq_qctl import efq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qcmd_t  cmd,
  output qstat_t stat
);

  logic [PTR_W-1:0] wp_r   [NUM_QUEUES];
  logic [PTR_W-1:0] rp_r   [NUM_QUEUES];
  logic             full_r [NUM_QUEUES];

  logic [PTR_W-1:0] wp_sel;
  logic [PTR_W-1:0] rp_sel;
  logic             full_sel;
  logic [PTR_W-1:0] ptr_in;
  logic [PTR_W-1:0] ptr_inc;

  // Read the selected queue
  assign wp_sel   = wp_r[cmd.sel];
  assign rp_sel   = rp_r[cmd.sel];
  assign full_sel = full_r[cmd.sel];

  assign stat.wp    = wp_sel;
  assign stat.rp    = rp_sel;
  assign stat.full  = full_sel;
  assign stat.empty = !full_sel && (wp_sel == rp_sel);

  // Shared pointer increment, wrapping at the queue depth
  assign ptr_in  = cmd.push ? wp_sel : rp_sel;
  assign ptr_inc = (int'(ptr_in) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(ptr_in + 1'b1);

  // Update the selected queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wp_r[i]   <= '0;
        rp_r[i]   <= '0;
        full_r[i] <= 1'b0;
      end
    end else if (cmd.init) begin
      wp_r[cmd.sel]   <= '0;
      rp_r[cmd.sel]   <= '0;
      full_r[cmd.sel] <= 1'b0;
    end else if (cmd.push) begin
      wp_r[cmd.sel]   <= ptr_inc;
      full_r[cmd.sel] <= (ptr_inc == rp_sel);
    end else if (cmd.pop) begin
      rp_r[cmd.sel]   <= ptr_inc;
      full_r[cmd.sel] <= 1'b0;
    end
  end

endmodule

>>> sv/efq_seq.sv
// Sequencer: takes one item, runs the subscribe, publish, pop or init steps
// against the listener table, the queue store and the pointer unit, and holds
// the result in an output register. Depends on efq_pkg and efq_if.
`timescale 1ns / 1ps

module efq_seq import efq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  efq_in_if.sink              in_ch,
  efq_out_if.source           out_ch,
  // listener table
  output logic                lt_we,
  output logic [LT_AW-1:0]    lt_waddr,
  output logic [QUEUE_W-1:0]  lt_wdata,
  output logic [LT_AW-1:0]    lt_raddr,
  input  logic [QUEUE_W-1:0]  lt_rdata,
  // queue store
  output logic                qs_we,
  output logic [QS_AW-1:0]    qs_waddr,
  output logic [EVENT_W-1:0]  qs_wdata,
  output logic [QS_AW-1:0]    qs_raddr,
  input  logic [EVENT_W-1:0]  qs_rdata,
  // pointer unit
  output qcmd_t               qcmd,
  input  qstat_t              qstat
);

  function automatic logic [LT_AW-1:0] lt_addr(input logic [EV_AW-1:0] ev,
                                               input logic [LC_W-1:0] li);
    lt_addr = LT_AW'(int'(ev) * LISTENERS_PER_EVENT + int'(li));
  endfunction

  function automatic logic [QS_AW-1:0] qs_addr(input logic [QI_W-1:0] qi,
                                               input logic [PTR_W-1:0] ptr);
    qs_addr = QS_AW'(int'(qi) * QUEUE_DEPTH + int'(ptr));
  endfunction

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [EVENT_W-1:0] ev_r, ev_nxt;
  logic [QUEUE_W-1:0] q_r, q_nxt;
  logic [LC_W-1:0]    idx_r, idx_nxt;
  logic [LC_W-1:0]    cnt_r, cnt_nxt;
  logic [LC_W-1:0]    dcnt_r, dcnt_nxt;
  logic [EVENT_W-1:0] evout_r, evout_nxt;
  logic               got_r, got_nxt;
  logic               ref_r, ref_nxt;

  logic [LC_W-1:0]    lcnt_r [NUM_EVENT_TYPES];
  logic               lcnt_we;

  logic               out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0] out_event_r, out_event_nxt;
  logic               out_got_r, out_got_nxt;
  logic               out_ref_r, out_ref_nxt;
  logic [DELIV_W-1:0] out_deliv_r, out_deliv_nxt;

  logic [EV_AW-1:0]   ev_idx;
  logic [QI_W-1:0]    q_idx;
  logic [QI_W-1:0]    tgt_idx;
  logic [LC_W-1:0]    lcnt_cur;
  logic [LC_W-1:0]    idx_inc;
  logic               ev_ok;
  logic               q_ok;
  logic               tgt_ok;

  assign ev_idx   = EV_AW'(ev_r);
  assign q_idx    = QI_W'(q_r);
  assign tgt_idx  = QI_W'(lt_rdata);
  assign lcnt_cur = lcnt_r[ev_idx];
  assign idx_inc  = LC_W'(idx_r + 1'b1);
  assign ev_ok    = int'(ev_r) < NUM_EVENT_TYPES;
  assign q_ok     = int'(q_r) < NUM_QUEUES;
  assign tgt_ok   = int'(lt_rdata) < NUM_QUEUES;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_out = out_event_r;
  assign out_ch.got_event = out_got_r;
  assign out_ch.refused   = out_ref_r;
  assign out_ch.delivered = out_deliv_r;

  // Sequence the steps of one item
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ev_nxt        = ev_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    dcnt_nxt      = dcnt_r;
    evout_nxt     = evout_r;
    got_nxt       = got_r;
    ref_nxt       = ref_r;
    lcnt_we       = 1'b0;
    lt_we         = 1'b0;
    lt_waddr      = lt_addr(ev_idx, lcnt_cur);
    lt_wdata      = q_r;
    lt_raddr      = lt_addr(ev_idx, '0);
    qs_we         = 1'b0;
    qs_waddr      = qs_addr(tgt_idx, qstat.wp);
    qs_wdata      = ev_r;
    qs_raddr      = qs_addr(q_idx, qstat.rp);
    qcmd          = '0;
    qcmd.sel      = q_idx;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_event_nxt = out_event_r;
    out_got_nxt   = out_got_r;
    out_ref_nxt   = out_ref_r;
    out_deliv_nxt = out_deliv_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.op);
          ev_nxt    = in_ch.event_id;
          q_nxt     = in_ch.queue_id;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          dcnt_nxt  = '0;
          evout_nxt = '0;
          got_nxt   = 1'b0;
          ref_nxt   = 1'b0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_r)
          OP_SUBSCRIBE: begin
            if (!ev_ok || !q_ok || int'(lcnt_cur) >= LISTENERS_PER_EVENT) begin
              ref_nxt = 1'b1;
            end else begin
              lt_we   = 1'b1;
              lcnt_we = 1'b1;
            end
            state_nxt = S_FIN;
          end
          OP_PUBLISH: begin
            // Issue the first listener read; the walk runs in S_LWAIT
            if (ev_ok && lcnt_cur != '0) begin
              cnt_nxt   = lcnt_cur;
              state_nxt = S_LWAIT;
            end else begin
              state_nxt = S_FIN;
            end
          end
          OP_POP: begin
            if (!q_ok || qstat.empty) begin
              ref_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              qcmd.pop  = 1'b1;
              got_nxt   = 1'b1;
              state_nxt = S_POPWAIT;
            end
          end
          OP_INIT: begin
            qcmd.init = q_ok;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_LWAIT: begin
        // Push into the listed queue unless it is full, read the next entry
        qcmd.sel = tgt_idx;
        if (tgt_ok && !qstat.full) begin
          qcmd.push = 1'b1;
          qs_we     = 1'b1;
          dcnt_nxt  = LC_W'(dcnt_r + 1'b1);
        end
        idx_nxt  = idx_inc;
        lt_raddr = lt_addr(ev_idx, idx_inc);
        if (idx_inc >= cnt_r) begin
          state_nxt = S_FIN;
        end
      end
      S_POPWAIT: begin
        evout_nxt = qs_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_event_nxt = evout_r;
          out_got_nxt   = got_r;
          out_ref_nxt   = ref_r;
          out_deliv_nxt = (int'(dcnt_r) > DELIV_MAX) ? DELIV_W'(DELIV_MAX)
                                                     : DELIV_W'(dcnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Listener counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_EVENT_TYPES; i++) begin
        lcnt_r[i] <= '0;
      end
    end else if (lcnt_we) begin
      lcnt_r[ev_idx] <= LC_W'(lcnt_cur + 1'b1);
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ev_r        <= ev_nxt;
    q_r         <= q_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    dcnt_r      <= dcnt_nxt;
    evout_r     <= evout_nxt;
    got_r       <= got_nxt;
    ref_r       <= ref_nxt;
    out_event_r <= out_event_nxt;
    out_got_r   <= out_got_nxt;
    out_ref_r   <= out_ref_nxt;
    out_deliv_r <= out_deliv_nxt;
  end

endmodule

>>> sv/event_fanout_queue_bus.sv
// Event fanout queue block, top level.
// Use: items arrive on in_bus (op, event_id, queue_id); one result per item
// leaves on out_bus (event_out, got_event, refused, delivered). Both are
// valid/ready channels; an item moves when valid and ready are high at a
// rising clock edge.
// Ops: subscribe appends queue_id to event_id's listener list, refused when
// full; publish pushes event_id into each listed queue in order, skipping
// full queues, and reports the count; pop returns a queue's oldest event or
// refused when empty; init empties a queue.
// Timing: one item at a time. in_bus.ready is high only while the sequencer
// is idle. After acceptance, subscribe and init pass through dispatch and the
// final step, pop adds a wait for the queue store read, and publish adds one
// listener step per entry of the event's list (one listener table read and,
// unless the queue is full, one queue push per cycle through the shared
// pointer unit). The result is registered in the final step.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, and that item's result waits in its last step until it frees.
// Reset (rst_n low, synchronous): all listener lists and queues empty, no
// result pending. Table and queue storage is not cleared and needs no pass.
// Depends on efq_pkg, efq_if, efq_ram, efq_qctl and efq_seq.
`timescale 1ns / 1ps

module event_fanout_queue_bus import efq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  efq_in_if.sink    in_bus,
  efq_out_if.source out_bus
);

  logic               lt_we;
  logic [LT_AW-1:0]   lt_waddr;
  logic [QUEUE_W-1:0] lt_wdata;
  logic [LT_AW-1:0]   lt_raddr;
  logic [QUEUE_W-1:0] lt_rdata;
  logic               qs_we;
  logic [QS_AW-1:0]   qs_waddr;
  logic [EVENT_W-1:0] qs_wdata;
  logic [QS_AW-1:0]   qs_raddr;
  logic [EVENT_W-1:0] qs_rdata;
  qcmd_t              qcmd;
  qstat_t             qstat;

  // Sequencer
  efq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .lt_we    (lt_we),
    .lt_waddr (lt_waddr),
    .lt_wdata (lt_wdata),
    .lt_raddr (lt_raddr),
    .lt_rdata (lt_rdata),
    .qs_we    (qs_we),
    .qs_waddr (qs_waddr),
    .qs_wdata (qs_wdata),
    .qs_raddr (qs_raddr),
    .qs_rdata (qs_rdata),
    .qcmd     (qcmd),
    .qstat    (qstat)
  );

  // Listener table: queue ids per event type and slot
  efq_ram #(.DW(QUEUE_W), .DEPTH(LT_DEPTH), .AW(LT_AW)) u_lt_ram (
    .clk   (clk),
    .we    (lt_we),
    .waddr (lt_waddr),
    .wdata (lt_wdata),
    .raddr (lt_raddr),
    .rdata (lt_rdata)
  );

  // Queue store: ring buffer slots of all queues
  efq_ram #(.DW(EVENT_W), .DEPTH(QS_DEPTH), .AW(QS_AW)) u_qs_ram (
    .clk   (clk),
    .we    (qs_we),
    .waddr (qs_waddr),
    .wdata (qs_wdata),
    .raddr (qs_raddr),
    .rdata (qs_rdata)
  );

  // Queue pointers and full flags
  efq_qctl u_qctl (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (qcmd),
    .stat  (qstat)
  );

endmodule

>>> sv/efq_checker.sv
// Port-level checker for the event fanout queue block, bound to the top level.
// Depends on efq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efq_checker import efq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [EVENT_W-1:0] event_out,
  input logic               got_event,
  input logic               refused,
  input logic [DELIV_W-1:0] delivered
);

  // A pending result stays until taken
  `EFQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // No result right after reset
  `EFQ_ASSERT_RST_NXT(a_rst_quiet, !rst_n, !out_valid, "result valid after reset")

  // One item at a time: busy after an item is taken
  `EFQ_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "item taken while busy")

  // A popped event excludes refusal and delivery count
  `EFQ_ASSERT_IMP(a_got_excl, out_valid && got_event, !refused && delivered == '0, "bad pop result")

  // Without a popped event the event field is zero
  `EFQ_ASSERT_IMP(a_ev_zero, out_valid && !got_event, event_out == '0, "stray event value")

endmodule

bind event_fanout_queue_bus efq_checker u_efq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .event_out (out_bus.event_out),
  .got_event (out_bus.got_event),
  .refused   (out_bus.refused),
  .delivered (out_bus.delivered)
);

>>> verif/tb.sv
// Self-checking testbench for event_fanout_queue_bus: directed and random
// subscribe/publish/pop/init traffic checked against an internal dispatcher model.
// Depends on efq_pkg, efq_if and the event_fanout_queue_bus RTL.
`timescale 1ns / 1ps

module tb;
  import efq_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    logic [EVENT_W-1:0] event_out;
    logic               got_event;
    logic               refused;
    logic [DELIV_W-1:0] delivered;
  } response_t;

  // Dispatcher model: listener lists, ring queues and the responses still owed
  class fanout_scoreboard;
    logic [QI_W-1:0]    listeners [NUM_EVENT_TYPES][LISTENERS_PER_EVENT];
    int unsigned        listener_cnt [NUM_EVENT_TYPES];
    logic [EVENT_W-1:0] slots [NUM_QUEUES][QUEUE_DEPTH];
    int unsigned        wr_ptr [NUM_QUEUES];
    int unsigned        rd_ptr [NUM_QUEUES];
    bit                 is_full [NUM_QUEUES];
    response_t          owed_responses [$];
    int unsigned        mismatches;

    function new();
      foreach (listener_cnt[e]) listener_cnt[e] = 0;
      foreach (wr_ptr[qi]) begin
        wr_ptr[qi] = 0;
        rd_ptr[qi] = 0;
        is_full[qi] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return owed_responses.size();
    endfunction

    // Push one event into a queue; drop it when the queue is full
    function bit push_event(logic [QI_W-1:0] qi, logic [EVENT_W-1:0] ev);
      if (is_full[qi]) return 1'b0;
      slots[qi][wr_ptr[qi]] = ev;
      wr_ptr[qi] = (wr_ptr[qi] + 1) % QUEUE_DEPTH;
      if (wr_ptr[qi] == rd_ptr[qi]) is_full[qi] = 1'b1;
      return 1'b1;
    endfunction

    // Apply one accepted item and queue the response it must produce
    function void note_request(op_t op, logic [EVENT_W-1:0] ev, logic [QUEUE_W-1:0] q);
      response_t   rsp;
      int unsigned n;
      rsp = '0;
      n = 0;
      case (op)
        OP_SUBSCRIBE: begin
          if (ev >= NUM_EVENT_TYPES || q >= NUM_QUEUES ||
              listener_cnt[ev] >= LISTENERS_PER_EVENT) begin
            rsp.refused = 1'b1;
          end else begin
            listeners[ev][listener_cnt[ev]] = q;
            listener_cnt[ev]++;
          end
        end
        OP_PUBLISH: begin
          if (ev < NUM_EVENT_TYPES) begin
            for (int i = 0; i < listener_cnt[ev]; i++) begin
              if (listeners[ev][i] < NUM_QUEUES && push_event(listeners[ev][i], ev)) n++;
            end
          end
          if (n > DELIV_MAX) n = DELIV_MAX;
          rsp.delivered = n[DELIV_W-1:0];
        end
        OP_POP: begin
          if (q >= NUM_QUEUES || (!is_full[q] && wr_ptr[q] == rd_ptr[q])) begin
            rsp.refused = 1'b1;
          end else begin
            rsp.event_out = slots[q][rd_ptr[q]];
            rd_ptr[q] = (rd_ptr[q] + 1) % QUEUE_DEPTH;
            is_full[q] = 1'b0;
            rsp.got_event = 1'b1;
          end
        end
        default: begin
          if (q < NUM_QUEUES) begin
            wr_ptr[q] = 0;
            rd_ptr[q] = 0;
            is_full[q] = 1'b0;
          end
        end
      endcase
      owed_responses.push_back(rsp);
    endfunction

    task report_mismatch(string what, logic [7:0] want, logic [7:0] seen);
      mismatches++;
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, seen);
    endtask

    // Compare one accepted response with the oldest owed one
    task check_response(response_t seen);
      response_t want;
      if (owed_responses.size() == 0) begin
        report_mismatch("unexpected response, event_out", 8'd0, 8'(seen.event_out));
      end else begin
        want = owed_responses.pop_front();
        if (seen.event_out !== want.event_out)
          report_mismatch("event_out", 8'(want.event_out), 8'(seen.event_out));
        if (seen.got_event !== want.got_event)
          report_mismatch("got_event", 8'(want.got_event), 8'(seen.got_event));
        if (seen.refused !== want.refused)
          report_mismatch("refused", 8'(want.refused), 8'(seen.refused));
        if (seen.delivered !== want.delivered)
          report_mismatch("delivered", 8'(want.delivered), 8'(seen.delivered));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic long_hold;
  int   cycles;

  efq_in_if  in_bus ();
  efq_out_if out_bus ();

  fanout_scoreboard sb = new();

  event_fanout_queue_bus u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > RUN_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Accept responses; stall at random, and once for a long stretch on request
  initial begin : response_sink
    int hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        sb.check_response({out_bus.event_out, out_bus.got_event,
                           out_bus.refused, out_bus.delivered});
      end
      if (long_hold !== hold_seen) begin
        hold_seen = long_hold;
        if (long_hold) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(op_t op, logic [EVENT_W-1:0] ev, logic [QUEUE_W-1:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.op       <= op;
    in_bus.event_id <= ev;
    in_bus.queue_id <= q;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    sb.note_request(op, ev, q);
  endtask

  // One random sequence: mostly bursts that fill or drain queues, some noise
  task automatic random_burst(inout int sent);
    int kind;
    int n;
    logic [EVENT_W-1:0] ev;
    logic [QUEUE_W-1:0] q;
    kind = $urandom_range(99);
    ev = EVENT_W'($urandom_range(NUM_EVENT_TYPES - 1));
    q  = QUEUE_W'($urandom_range(NUM_QUEUES - 1));
    if (kind < 20) begin
      send_item(OP_SUBSCRIBE, ev, q);
      sent++;
    end else if (kind < 50) begin
      n = $urandom_range(6, 1);
      repeat (n) send_item(OP_PUBLISH, ev, QUEUE_W'($urandom_range(NUM_QUEUES - 1)));
      sent += n;
    end else if (kind < 82) begin
      n = $urandom_range(9, 1);
      repeat (n) send_item(OP_POP, EVENT_W'($urandom_range(NUM_EVENT_TYPES - 1)), q);
      sent += n;
    end else if (kind < 88) begin
      send_item(OP_INIT, ev, q);
      sent++;
    end else begin
      send_item(op_t'($urandom_range(3)), ev, q);
      sent++;
    end
  endtask

  initial begin : stimulus
    int sent;
    rst_n          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.op       <= OP_SUBSCRIBE;
    in_bus.event_id <= '0;
    in_bus.queue_id <= '0;
    send_idle_pct  <= 11;
    recv_idle_pct  <= 82;
    long_hold      <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, publish with no listeners, extreme ids
    send_item(OP_POP, 4'd0, 3'd0);
    send_item(OP_PUBLISH, 4'd0, 3'd0);
    send_item(OP_SUBSCRIBE, 4'd15, 3'd7);
    // Duplicate listeners fill event 5's list, then one more is refused
    repeat (LISTENERS_PER_EVENT) send_item(OP_SUBSCRIBE, 4'd5, 3'd2);
    send_item(OP_SUBSCRIBE, 4'd5, 3'd3);
    // Fill queue 2, then publish into the full queue
    send_item(OP_PUBLISH, 4'd5, 3'd0);
    send_item(OP_PUBLISH, 4'd5, 3'd0);
    send_item(OP_PUBLISH, 4'd5, 3'd0);
    // Pop from the full queue frees one slot, refill it
    send_item(OP_POP, 4'd0, 3'd2);
    send_item(OP_PUBLISH, 4'd5, 3'd0);
    send_item(OP_PUBLISH, 4'd15, 3'd0);
    send_item(OP_POP, 4'd15, 3'd7);
    send_item(OP_POP, 4'd15, 3'd7);
    // Init empties a full queue
    send_item(OP_INIT, 4'd0, 3'd2);
    send_item(OP_POP, 4'd0, 3'd2);
    // Event zero round trip
    send_item(OP_SUBSCRIBE, 4'd0, 3'd0);
    send_item(OP_PUBLISH, 4'd0, 3'd0);
    send_item(OP_POP, 4'd0, 3'd0);
    send_item(OP_INIT, 4'd15, 3'd7);

    // Random: three idle profiles, long receiver hold at the start of the last
    sent = 0;
    while (sent < RANDOM_ITEMS / 3) random_burst(sent);
    send_idle_pct <= 82;
    recv_idle_pct <= 11;
    while (sent < 2 * RANDOM_ITEMS / 3) random_burst(sent);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    long_hold     <= 1'b1;
    while (sent < RANDOM_ITEMS) random_burst(sent);

    // Drain and finish
    in_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/efq_pkg.sv
sv/efq_if.sv
sv/efq_ram.sv
sv/efq_qctl.sv
sv/efq_seq.sv
sv/event_fanout_queue_bus.sv
sv/efq_checker.sv
verif/tb.sv
